### hdl/splk_pkg.sv
// ----------------------------------------------------------------------------
// splk_pkg
// Shared constants for the spectrum peak lock detector: register indexes,
// stream packing and fixed arithmetic limits.
// ----------------------------------------------------------------------------
package splk_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 33;

	localparam logic [CFG_IDX_W-1:0] REG_POWER_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_FREQ      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLICING_MODE    = 3'd5;

	// stream packing
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_RUN_BIT = 33;
	localparam int OUT_LCK_BIT = 34;
	localparam int OUT_RES_LSB = 35;
	localparam int OUT_UPD_BIT = 68;

	// fixed arithmetic
	localparam int HALF_BINS      = 120;
	localparam int CHAN_TOL       = 2;
	localparam int MAX_WEIGHT     = 16;
	localparam int RELEASE_MISSES = 6;
	localparam int FREQ_W         = 33;
	localparam int SF_W           = 34;
	localparam int SUM_W          = 40;
	localparam int DIVD_W         = 39;
	localparam logic [FREQ_W-1:0] F33_MAX   = 33'h1_FFFF_FFFF;
	localparam logic [23:0]       SUM24_MAX = 24'hFF_FFFF;

endpackage

### hdl/splk_div.sv
// ----------------------------------------------------------------------------
// splk_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module splk_div #(
	parameter int DW = 39,
	parameter int VW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial    = {rem_q, quo_q[DW-1]};
	assign fits     = trial >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

endmodule

### hdl/spectrum_peak_lock_detector_unit.sv
// ----------------------------------------------------------------------------
// spectrum_peak_lock_detector_unit
// Per-frame peak search over spectrum bins, per-slice peak store and lock
// detection with frequency averaging.
// ----------------------------------------------------------------------------
// A bin without the end mark is accepted back to back. A frame end that
//   skips detection goes to ST_OUT, which loads its result once the output
//   register is free; s_tready stays low until then.
// A detection frame runs from its accept edge to the result through the mean
//   division (a bit-serial divider pass), the slice scan (one store read per
//   slice), the estimate, the lock update, the resolve division (a second
//   divider pass) and the output load; a stalled result holds in ST_OUT.
//   s_tready stays low meanwhile.
// Reset: arst_n clears all control state; the slice store holds no reset value.
// ----------------------------------------------------------------------------
module spectrum_peak_lock_detector_unit #(
	parameter int MAX_SLICES     = 32,
	parameter int SLICE_WIDTH_HZ = 2500000,
	parameter int BIN_WIDTH_HZ   = 9766,
	parameter int BIN_STRIDE     = 256,
	parameter int MEAN_BINS      = 240
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// bin item in
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [splk_pkg::IN_TDATA_W-1:0]    s_tdata,  // bin_power[7:0], bin_pos[15:8]
	input  logic                               s_tlast,  // frame_end
	// result item out
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// next_center_freq[32:0], detection_run[33], locked[34],
	// resolved_freq[67:35], freq_updated[68], zero fill
	output logic [splk_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [splk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [splk_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW   = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam int NW   = $clog2(MAX_SLICES + 1);
	localparam int MDW  = $clog2(MEAN_BINS * MAX_SLICES + 1);
	localparam int DVW  = (MDW > 5) ? MDW : 5;
	localparam int BWW  = $clog2(BIN_WIDTH_HZ + 1);
	localparam int PW   = 17 + BWW;
	localparam int EW   = 42;
	localparam logic signed [EW-1:0] S40_MAX = EW'(64'sd549755813887);
	localparam logic signed [EW-1:0] S40_MIN = -EW'(64'sd549755813888);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MEAN, ST_SCAN, ST_EST, ST_LOCK, ST_RES, ST_OUT
	} state_t;

	// configuration registers
	logic [7:0]                  thr_q;
	logic [5:0]                  slice_count_q;
	logic [splk_pkg::FREQ_W-1:0] start_q, low_q, high_q;
	logic                        slicing_q;

	// block state
	state_t                        state_q;
	logic [7:0]                    fpp_q;
	logic signed [9:0]             fpi_q;
	logic [23:0]                   power_sum_q;
	logic [AW-1:0]                 slice_index_q;
	logic signed [15:0]            prev_chan_q;
	logic [2:0]                    repeat_q;
	logic [2:0]                    miss_q;
	logic                          lock_q;
	logic signed [15:0]            lock_chan_q;
	logic [4:0]                    weight_q;
	logic signed [splk_pkg::SUM_W-1:0] freq_sum_q;
	logic [splk_pkg::FREQ_W-1:0]   resolved_q;

	// per-frame work registers
	logic                          ran_q, upd_q;
	logic [NW-1:0]                 n_q, issue_q;
	logic [splk_pkg::SF_W-1:0]     sf_det_q;
	logic [23:0]                   mean_q;
	logic [7:0]                    best_q;
	logic signed [15:0]            chan_q;
	logic signed [PW-1:0]          prod_q;
	logic                          rdv_s1;
	logic [AW-1:0]                 c_s1;
	logic                          div_start_q;

	// output register
	logic                          m_tvalid_q;
	logic [splk_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	// slice peak store: {index, power}
	logic [17:0] slice_mem [MAX_SLICES];
	logic [17:0] mem_rd_q;

	function automatic logic [splk_pkg::SF_W-1:0] slice_freq(
		input logic [splk_pkg::FREQ_W-1:0] base, input logic [AW-1:0] idx);
		return splk_pkg::SF_W'(base) +
			splk_pkg::SF_W'(idx) * splk_pkg::SF_W'(SLICE_WIDTH_HZ);
	endfunction

	function automatic logic [2:0] lock_need(input logic [NW-1:0] n);
		case (int'(n))
			1:       return 3'd5;
			2:       return 3'd2;
			3, 4, 5: return 3'd1;
			default: return 3'd0;
		endcase
	endfunction

	function automatic logic signed [splk_pkg::SUM_W-1:0] sat40(input logic signed [EW-1:0] v);
		if (v > S40_MAX) return splk_pkg::SUM_W'(S40_MAX);
		if (v < S40_MIN) return splk_pkg::SUM_W'(S40_MIN);
		return v[splk_pkg::SUM_W-1:0];
	endfunction

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= 8'd80;
			slice_count_q <= 6'd1;
			start_q       <= '0;
			low_q         <= '0;
			high_q        <= '0;
			slicing_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				splk_pkg::REG_POWER_THRESHOLD: thr_q         <= cfg_data[7:0];
				splk_pkg::REG_SLICE_COUNT:     slice_count_q <= cfg_data[5:0];
				splk_pkg::REG_START_FREQ:      start_q       <= cfg_data;
				splk_pkg::REG_RANGE_LOW:       low_q         <= cfg_data;
				splk_pkg::REG_RANGE_HIGH:      high_q        <= cfg_data;
				splk_pkg::REG_SLICING_MODE:    slicing_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- bin path
	logic        accept;
	logic [7:0]  bin_power, bin_pos;
	logic [24:0] ps_raw;
	logic [23:0] ps_new;
	logic        take;
	logic [7:0]  pk_pow;
	logic signed [9:0] pos_idx, pk_idx;
	logic [NW-1:0] eff_n, n_cur;
	logic [AW-1:0] slot;
	logic          det_go;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign bin_power = s_tdata[7:0];
	assign bin_pos   = s_tdata[15:8];
	assign ps_raw    = {1'b0, power_sum_q} + 25'(bin_power);
	assign ps_new    = ps_raw[24] ? splk_pkg::SUM24_MAX : ps_raw[23:0];
	assign take      = bin_power > fpp_q;
	// left half shifts down by the tolerance, right half up
	assign pos_idx   = (int'(bin_pos) < splk_pkg::HALF_BINS) ?
		$signed(10'(bin_pos)) - 10'sd2 : $signed(10'(bin_pos)) + 10'sd2;
	assign pk_pow    = take ? bin_power : fpp_q;
	assign pk_idx    = take ? pos_idx : fpi_q;

	always_comb begin
		if (slice_count_q == '0)
			eff_n = NW'(1);
		else if (int'(slice_count_q) > MAX_SLICES)
			eff_n = NW'(MAX_SLICES);
		else
			eff_n = NW'(slice_count_q);
	end

	assign n_cur  = slicing_q ? eff_n : NW'(1);
	assign slot   = slicing_q ? slice_index_q : '0;
	// a lowered slice count makes the current slice the last one
	assign det_go = !slicing_q || (int'(slice_index_q) >= int'(n_cur) - 1);

	// ---------------------------------------------------------------- store
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	assign rd_en   = (state_q == ST_SCAN) && (issue_q < n_q);
	assign rd_addr = issue_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (accept && s_tlast)
			slice_mem[slot] <= {pk_idx, pk_pow};
		if (rd_en)
			mem_rd_q <= slice_mem[rd_addr];
	end

	// ---------------------------------------------------------------- divider
	logic [splk_pkg::DIVD_W-1:0] div_dvd, div_quo;
	logic [DVW-1:0]              div_dvs;
	logic                        div_done;

	assign div_dvd = (state_q == ST_RES) ? freq_sum_q[splk_pkg::DIVD_W-1:0]
		: splk_pkg::DIVD_W'(power_sum_q);
	assign div_dvs = (state_q == ST_RES) ? DVW'(weight_q)
		: DVW'(n_q) * DVW'(MEAN_BINS);

	splk_div #(
		.DW(splk_pkg::DIVD_W),
		.VW(DVW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_quo)
	);

	// ---------------------------------------------------------------- scan eval
	logic [7:0]         rd_pow;
	logic signed [9:0]  rd_idx;
	logic signed [15:0] rd_chan;
	logic               rd_hit;

	assign rd_pow  = mem_rd_q[7:0];
	assign rd_idx  = $signed(mem_rd_q[17:8]);
	// slice channels sit one stride apart, wrapping at 16 bits
	assign rd_chan = 16'(rd_idx) + 16'(32'(c_s1) * BIN_STRIDE);
	assign rd_hit  = (rd_pow >= thr_q) && (24'(rd_pow - thr_q) >= mean_q) && (rd_pow > best_q);

	// ---------------------------------------------------------------- lock math
	logic signed [16:0] cdiff;
	logic signed [17:0] ch18, pv18;
	logic               in_tol;
	logic signed [EW-1:0] est, acc;
	logic signed [splk_pkg::SUM_W-1:0] fs_first;
	logic               in_range;
	logic [splk_pkg::FREQ_W-1:0] res_sat;

	assign cdiff    = 17'(chan_q) - 17'(splk_pkg::HALF_BINS);
	assign ch18     = 18'(chan_q);
	assign pv18     = 18'(prev_chan_q);
	assign in_tol   = (ch18 >= pv18 - 18'sd2) && (ch18 <= pv18 + 18'sd2) && (chan_q != 16'sd0);
	assign est      = $signed({8'b0, sf_det_q}) + EW'(prod_q);
	assign acc      = EW'(freq_sum_q) + est;
	assign fs_first = sat40(est);
	assign in_range = (fs_first >= $signed({1'b0, low_q})) && (fs_first <= $signed({1'b0, high_q}));
	assign res_sat  = (div_quo > splk_pkg::DIVD_W'(splk_pkg::F33_MAX)) ? splk_pkg::F33_MAX
		: div_quo[splk_pkg::FREQ_W-1:0];

	// ---------------------------------------------------------------- control
	logic [splk_pkg::SF_W-1:0] sf_out;
	assign sf_out = slice_freq(start_q, slice_index_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fpp_q         <= '0;
			fpi_q         <= '0;
			power_sum_q   <= '0;
			slice_index_q <= '0;
			prev_chan_q   <= '0;
			repeat_q      <= '0;
			miss_q        <= '0;
			lock_q        <= 1'b0;
			lock_chan_q   <= '0;
			weight_q      <= 5'd1;
			freq_sum_q    <= '0;
			resolved_q    <= '0;
			ran_q         <= 1'b0;
			upd_q         <= 1'b0;
			n_q           <= '0;
			issue_q       <= '0;
			sf_det_q      <= '0;
			mean_q        <= '0;
			best_q        <= '0;
			chan_q        <= '0;
			prod_q        <= '0;
			rdv_s1        <= 1'b0;
			c_s1          <= '0;
			div_start_q   <= 1'b0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			// start is a one-cycle pulse; it is never raised while already high
			if (div_start_q)
				div_start_q <= 1'b0;
			// ST_OUT reloads the register itself when the item leaves
			if (m_tvalid_q && m_tready && state_q != ST_OUT)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						power_sum_q <= ps_new;
						if (!s_tlast) begin
							fpp_q <= pk_pow;
							fpi_q <= pk_idx;
						end else begin
							// close the frame: peak went to the store this edge
							fpp_q    <= '0;
							fpi_q    <= '0;
							ran_q    <= det_go;
							upd_q    <= 1'b0;
							sf_det_q <= slice_freq(start_q, slot);
							n_q      <= n_cur;
							if (det_go) begin
								slice_index_q <= '0;
								div_start_q   <= 1'b1;
								state_q       <= ST_MEAN;
							end else begin
								slice_index_q <= slice_index_q + 1'b1;
								state_q       <= ST_OUT;
							end
						end
					end
				end
				ST_MEAN: begin
					if (div_done) begin
						mean_q      <= div_quo[23:0];
						power_sum_q <= slicing_q ? 24'd0 : div_quo[23:0];
						issue_q     <= '0;
						best_q      <= '0;
						chan_q      <= '0;
						rdv_s1      <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one read per cycle, evaluate it the cycle after
					rdv_s1 <= rd_en;
					c_s1   <= rd_addr;
					if (rd_en)
						issue_q <= issue_q + 1'b1;
					if (rdv_s1 && rd_hit) begin
						best_q <= rd_pow;
						chan_q <= rd_chan;
					end
					if (!rd_en && !rdv_s1)
						state_q <= ST_EST;
				end
				ST_EST: begin
					prod_q  <= PW'(cdiff) * PW'(BIN_WIDTH_HZ);
					state_q <= ST_LOCK;
				end
				ST_LOCK: begin
					if (in_tol) begin
						if (repeat_q >= lock_need(n_q)) begin
							if (chan_q != lock_chan_q || !lock_q) begin
								if (lock_q) begin
									if (int'(weight_q) < splk_pkg::MAX_WEIGHT) begin
										freq_sum_q <= sat40(acc);
										weight_q   <= weight_q + 1'b1;
									end
								end else begin
									freq_sum_q <= fs_first;
									if (in_range) begin
										lock_q      <= 1'b1;
										weight_q    <= 5'd1;
										lock_chan_q <= chan_q;
									end
								end
								upd_q <= 1'b1;
							end
							miss_q <= '0;
						end else begin
							repeat_q <= repeat_q + 1'b1;
						end
					end else begin
						repeat_q <= '0;
						if (lock_q) begin
							if (int'(miss_q) == splk_pkg::RELEASE_MISSES)
								lock_q <= 1'b0;
							else
								miss_q <= miss_q + 1'b1;
						end
					end
					prev_chan_q <= chan_q;
					div_start_q <= 1'b1;
					state_q     <= ST_RES;
				end
				ST_RES: begin
					if (div_done) begin
						// a negative sum truncates to zero or below: clamp
						resolved_q <= freq_sum_q[splk_pkg::SUM_W-1] ? '0 : res_sat;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b0, upd_q, resolved_q, lock_q, ran_q,
							sf_out[splk_pkg::SF_W-1] ? splk_pkg::F33_MAX
								: sf_out[splk_pkg::FREQ_W-1:0]};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### hdl/splk_checker.sv
// ----------------------------------------------------------------------------
// splk_checker
// Port-level checks for the spectrum peak lock detector, bound to the top.
// ----------------------------------------------------------------------------
module splk_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             s_tlast,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [splk_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// the frequency is only recomputed by a detection step
	a_upd_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[splk_pkg::OUT_UPD_BIT] && !m_tdata[splk_pkg::OUT_RUN_BIT]))
		else $error("freq_updated without detection_run");

	// a frame end item blocks the next bin while the frame closes
	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("bin accepted right after frame end");

endmodule

bind spectrum_peak_lock_detector_unit splk_checker u_splk_checker (.*);

### verif/splk_checker.sv
// ----------------------------------------------------------------------------
// splk_scoreboard
// Watches the bin, result and register channels of the peak lock detector,
// keeps its own copy of the detector state, predicts one result item per
// frame end and compares each delivered result against the oldest prediction.
// ----------------------------------------------------------------------------
module splk_scoreboard
	import splk_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     errors,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     SLICES   = 32;
	localparam longint SLICE_HZ = 2500000;
	localparam longint BIN_HZ   = 9766;
	localparam int     STRIDE   = 256;
	localparam int     MEAN_W   = 240;
	localparam longint S40_HI   = 64'sd549755813887;
	localparam longint S40_LO   = -64'sd549755813888;

	typedef struct packed {
		logic [FREQ_W-1:0] center;
		logic              run;
		logic              lck;
		logic [FREQ_W-1:0] res;
		logic              upd;
	} lock_report_t;

	lock_report_t report_q[$];
	int           mismatches;

	// configuration copy
	logic [7:0]        thr;
	logic [5:0]        slice_cnt;
	logic [FREQ_W-1:0] f_start, f_lo, f_hi;
	logic              slicing;

	// detector state copy
	logic [7:0] pk_pow;
	int         pk_chan;
	int         mean_acc;
	logic [7:0] store_pow [SLICES];
	int         store_chan [SLICES];
	int         sidx;
	int         prev_chan;
	int         repeats;
	int         misses;
	bit         lock_on;
	int         lock_chan;
	int         weight;
	longint     fsum;

	function automatic void clear_state();
		thr = 8'd80; slice_cnt = 6'd1; f_start = '0; f_lo = '0; f_hi = '0; slicing = 1'b0;
		pk_pow = '0; pk_chan = 0; mean_acc = 0;
		for (int i = 0; i < SLICES; i++) begin
			store_pow[i] = '0;
			store_chan[i] = 0;
		end
		sidx = 0; prev_chan = 0; repeats = 0; misses = 0;
		lock_on = 1'b0; lock_chan = 0; weight = 1; fsum = 0;
	endfunction

	function automatic longint center_hz();
		return longint'(f_start) + longint'(sidx) * SLICE_HZ;
	endfunction

	// strongest qualifying slice peak, then repeat / lock / release bookkeeping
	function automatic bit detect_peak(int n, longint sf);
		int               best;
		int               chan;
		bit               upd;
		logic signed [15:0] w16;
		longint           est;
		best = 0; chan = 0; upd = 1'b0;
		mean_acc = mean_acc / (MEAN_W * n);
		for (int c = 0; c < n && c < SLICES; c++) begin
			if (store_pow[c] >= thr && int'(store_pow[c]) - int'(thr) >= mean_acc
					&& int'(store_pow[c]) > best) begin
				best = store_pow[c];
				w16  = 16'(store_chan[c] + c * STRIDE);
				chan = w16;
			end
		end
		if (chan >= prev_chan - CHAN_TOL && chan <= prev_chan + CHAN_TOL && chan != 0) begin
			if (repeats >= 5 / n) begin
				if (chan != lock_chan || !lock_on) begin
					est = sf + BIN_HZ * longint'(chan - HALF_BINS);
					if (lock_on) begin
						if (weight < MAX_WEIGHT) begin
							fsum = fsum + est;
							if (fsum > S40_HI) fsum = S40_HI;
							if (fsum < S40_LO) fsum = S40_LO;
							weight++;
						end
					end else begin
						fsum = est;
						if (fsum > S40_HI) fsum = S40_HI;
						if (fsum < S40_LO) fsum = S40_LO;
						if (fsum >= longint'(f_lo) && fsum <= longint'(f_hi)) begin
							lock_on = 1'b1;
							weight = 1;
							lock_chan = chan;
						end
					end
					upd = 1'b1;
				end
				misses = 0;
			end else begin
				repeats++;
			end
		end else begin
			repeats = 0;
			if (lock_on) begin
				if (misses == RELEASE_MISSES) lock_on = 1'b0;
				else misses++;
			end
		end
		prev_chan = chan;
		return upd;
	endfunction

	// advance the model by one bin; returns 1 when a result item is due
	function automatic bit predict_bin(logic [7:0] pw, logic [7:0] pos, logic fend,
			output lock_report_t r);
		int     n;
		int     slot;
		bit     ran;
		bit     upd;
		longint sf;
		longint q;
		ran = 1'b0; upd = 1'b0; r = '0;
		mean_acc = mean_acc + pw;
		if (mean_acc > int'(SUM24_MAX)) mean_acc = SUM24_MAX;
		if (pw > pk_pow) begin
			pk_pow  = pw;
			pk_chan = (pos < HALF_BINS) ? int'(pos) - CHAN_TOL : int'(pos) + CHAN_TOL;
		end
		if (!fend) return 1'b0;

		if (slicing) begin
			n = (slice_cnt < 1) ? 1 : (slice_cnt > SLICES) ? SLICES : slice_cnt;
			slot = sidx;
		end else begin
			n = 1; slot = 0; sidx = 0;
		end
		if (slot < SLICES) begin
			store_pow[slot]  = pk_pow;
			store_chan[slot] = pk_chan;
		end
		pk_pow = '0;
		pk_chan = 0;

		sf = center_hz();
		if (slicing) begin
			if (sidx >= n - 1) begin
				upd = detect_peak(n, sf);
				ran = 1'b1;
				mean_acc = 0;
				sidx = 0;
			end else begin
				sidx++;
			end
		end else begin
			upd = detect_peak(1, sf);
			ran = 1'b1;
		end

		sf = center_hz();
		r.center = (sf > longint'(F33_MAX)) ? F33_MAX : FREQ_W'(sf);
		r.run = ran;
		r.lck = lock_on;
		q = fsum / longint'(weight);
		r.res = (q < 0) ? '0 : (q > longint'(F33_MAX)) ? F33_MAX : FREQ_W'(q);
		r.upd = upd;
		return 1'b1;
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lock_report_t r;
		lock_report_t want;
		if (!arst_n) begin
			clear_state();
			report_q.delete();
			mismatches = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POWER_THRESHOLD: thr       = cfg_data[7:0];
					REG_SLICE_COUNT:     slice_cnt = cfg_data[5:0];
					REG_START_FREQ:      f_start   = cfg_data[FREQ_W-1:0];
					REG_RANGE_LOW:       f_lo      = cfg_data[FREQ_W-1:0];
					REG_RANGE_HIGH:      f_hi      = cfg_data[FREQ_W-1:0];
					REG_SLICING_MODE:    slicing   = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (predict_bin(s_tdata[7:0], s_tdata[15:8], s_tlast, r))
					report_q.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				if (report_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result item with nothing expected", $realtime);
				end else begin
					want = report_q.pop_front();
					check_field("next_center_freq", want.center, m_tdata[FREQ_W-1:0]);
					check_field("detection_run", want.run, m_tdata[OUT_RUN_BIT]);
					check_field("locked", want.lck, m_tdata[OUT_LCK_BIT]);
					check_field("resolved_freq", want.res, m_tdata[OUT_RES_LSB +: FREQ_W]);
					check_field("freq_updated", want.upd, m_tdata[OUT_UPD_BIT]);
				end
			end
			errors  <= mismatches;
			pending <= report_q.size();
		end
	end

endmodule

### verif/spectrum_peak_lock_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// spectrum_peak_lock_detector_unit_tb
// Drives bin frames and register settings into the peak lock detector, with
// random idling on both streams; a side checker predicts and compares every
// result item and the top gives the verdict.
// ----------------------------------------------------------------------------
module spectrum_peak_lock_detector_unit_tb;
	import splk_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 150;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // bin_power[7:0], bin_pos[15:8]
	logic                   s_tlast = 1'b0; // frame_end
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // next_center_freq, run, locked, resolved, updated
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int  errors;
	int  pending;
	bit  idle_en = 1'b1;
	int  cur_thr = 80;
	int  sent;
	int  quiet_cycles = 0;
	int  stall_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	spectrum_peak_lock_detector_unit u_top (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_we, .cfg_index, .cfg_data
	);

	splk_scoreboard u_checker (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_we, .cfg_index, .cfg_data,
		.errors, .pending
	);

	// receiver back-pressure: random stall bursts while idling is on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// end the run if nothing moves on either stream for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("spectrum_peak_lock_detector_unit verification failed");
			$finish;
		end
	end

	// write one register; leave a free cycle so the enable never toggles in one step
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// present one bin and hold it until accepted
	task automatic send_bin(int pw, int pos, bit last);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {8'(pos), 8'(pw)};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// a frame of len bins with one chosen peak bin among random noise bins up to noise_max
	task automatic send_frame(int len, int peak_pos, int peak_pw, int noise_max);
		int at;
		at = $urandom_range(0, len - 1);
		for (int i = 0; i < len; i++) begin
			if (i == at) send_bin(peak_pw, peak_pos, i == len - 1);
			else send_bin($urandom_range(0, noise_max), $urandom_range(0, 255), i == len - 1);
		end
	endtask

	// hold the sender until every result has come and the block has settled
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly steady peaks that build and hold a lock, the rest noise frames
	task automatic random_phase(int budget, int max_len);
		int stop_at;
		int pos;
		int pw;
		int runs;
		stop_at = sent + budget;
		while (sent < stop_at) begin
			if ($urandom_range(0, 9) < 7) begin
				pos  = $urandom_range(0, 255);
				pw   = $urandom_range(cur_thr, 255);
				runs = $urandom_range(3, 14);
				for (int k = 0; k < runs; k++) begin
					// occasional near-equal neighbor keeps the repeat chain alive
					send_frame($urandom_range(1, max_len),
						($urandom_range(0, 5) == 0) ? (pos ^ 1) : pos, pw, cur_thr / 2);
				end
			end else begin
				send_frame($urandom_range(1, max_len), $urandom_range(0, 255),
					$urandom_range(0, 255), 255);
			end
		end
	endtask

	task automatic set_thr(int v);
		cur_thr = v;
		write_reg(REG_POWER_THRESHOLD, v);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, both halves, positions past 239, out-of-range estimate
		send_bin(0, 0, 1'b1);
		send_bin(255, 0, 1'b1);
		send_bin(255, 119, 1'b0);
		send_bin(254, 120, 1'b1);
		send_bin(200, 239, 1'b1);
		send_bin(200, 240, 1'b0);
		send_bin(201, 255, 1'b1);
		for (int i = 0; i < 8; i++) send_bin(255, 60, 1'b1);
		for (int i = 0; i < 8; i++) send_bin(128, 170, i[0]);
		drain();

		// single mode with a wide accept range: locks, averaging, releases
		set_thr(60);
		write_reg(REG_SLICE_COUNT, 1);
		write_reg(REG_START_FREQ, 64'd100_000_000);
		write_reg(REG_RANGE_LOW, 64'd50_000_000);
		write_reg(REG_RANGE_HIGH, 64'd7_250_000_000);
		write_reg(REG_SLICING_MODE, 1);
		write_reg(REG_SLICING_MODE, 0);
		random_phase(90, 6);
		drain();

		// slicing over three slices
		set_thr(40);
		write_reg(REG_SLICING_MODE, 1);
		write_reg(REG_SLICE_COUNT, 3);
		random_phase(70, 4);
		drain();

		// widest sweep, only full-scale peaks qualify
		set_thr(255);
		write_reg(REG_SLICE_COUNT, 32);
		random_phase(90, 2);
		drain();

		// count of zero acts as one; top start frequency, empty accept range
		set_thr(0);
		write_reg(REG_SLICE_COUNT, 0);
		write_reg(REG_START_FREQ, 64'd7_250_000_000);
		write_reg(REG_RANGE_LOW, 0);
		write_reg(REG_RANGE_HIGH, 0);
		random_phase(40, 4);
		drain();

		// count above the maximum; one loud frame then a full sweep of slices
		set_thr(80);
		write_reg(REG_SLICE_COUNT, 63);
		write_reg(REG_START_FREQ, 0);
		write_reg(REG_RANGE_HIGH, 64'd7_250_000_000);
		for (int i = 0; i < 8; i++) send_bin(255, i * 30, i == 7);
		for (int i = 0; i < 31; i++) send_frame($urandom_range(1, 3), 30, 255, 40);
		drain();

		// single mode, a full-width loud frame lifts the mean above the margin;
		// finish with no idling on either side
		write_reg(REG_SLICING_MODE, 0);
		for (int i = 0; i < 240; i++) send_bin(200, i, i == 239);
		send_frame(3, 100, 230, 10);
		idle_en = 1'b0;
		random_phase(60, 5);
		drain();

		if (errors == 0 && pending == 0) begin
			$display("spectrum_peak_lock_detector_unit verification clean");
		end else begin
			$display("spectrum_peak_lock_detector_unit verification failed");
		end
		$finish;
	end

endmodule
